>>> sv/assert_macros.svh
// assertion macros used by the rtl of the box blur block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BB3_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bb3 assertion failed");

// condition must never be seen at a clock edge outside reset
`define BB3_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bb3 forbidden condition seen");

`else

`define BB3_ASSERT(lbl, clk, rstn, prop)
`define BB3_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> sv/bb3_pkg.sv
// types, constants and helper functions of the 3x3 box blur
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned FRAME_W_W = 11;
  localparam int unsigned FRAME_H_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  localparam logic [FRAME_W_W-1:0] WIDTH_RST  = FRAME_W_W'(640);
  localparam logic [FRAME_H_W-1:0] HEIGHT_RST = FRAME_H_W'(480);

  // floor(p / 9) for 8-bit p as (p * 57) >> 9, exact over 0..255
  localparam int unsigned RECIP9   = 57;
  localparam int unsigned RECIP_SH = 9;
  localparam int unsigned PROD_W   = 14;
  localparam int unsigned DIV_W    = PROD_W - RECIP_SH;
  localparam int unsigned COLSUM_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_pixel_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             last_of_input;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // rows r-2 and r-1 of one column
  typedef struct packed {
    rgb_t upper;
    rgb_t lower;
  } line_pair_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] red;
    logic [COLSUM_W-1:0] green;
    logic [COLSUM_W-1:0] blue;
  } colsum_t;

  // what one input leaves for the output queue
  typedef struct packed {
    logic    int_v;
    logic    brd_v;
    result_t int_res;
    result_t brd_res;
  } res_load_t;

  function automatic logic [DIV_W-1:0] div9(logic [CH_W-1:0] p);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(p) * PROD_W'(RECIP9);
    return prod[PROD_W-1:RECIP_SH];
  endfunction

  function automatic colsum_t col_sum(rgb_t a, rgb_t b, rgb_t c);
    colsum_t s;
    s.red   = COLSUM_W'(div9(a.red))   + COLSUM_W'(div9(b.red))   + COLSUM_W'(div9(c.red));
    s.green = COLSUM_W'(div9(a.green)) + COLSUM_W'(div9(b.green)) + COLSUM_W'(div9(c.green));
    s.blue  = COLSUM_W'(div9(a.blue))  + COLSUM_W'(div9(b.blue))  + COLSUM_W'(div9(c.blue));
    return s;
  endfunction

endpackage

>>> sv/rgb_box_blur_3x3.sv
// top level of the 3x3 box blur for raster-order rgb frames
//
//  channel  direction  handshake                      beat
//  in       input      in_valid_i / in_ready_o        in_data_i   (in_pixel_t)
//  out      output     out_valid_o / out_ready_i      out_data_o  (result_t)
//  cfg      input      cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// a pixel beat is taken every cycle while the output keeps up; a pixel that
// yields two results holds the input while the second result drains
// from input beat to first result beat, the line store is read and the
// input stage loaded at acceptance, then the window sum enters the result queue
// the single line memory is read when a beat is taken and written when it leaves
// the input stage, so both ports work at one pixel per clock unless stalled
// reset clears counters, window and queue; line stores are not cleared
// a stalled output holds the head of the two-slot queue and backs up the input
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_box_blur_3x3 import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_pixel_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned EWM = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW  = (EWM > FRAME_W_W) ? EWM : FRAME_W_W;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);

  // configuration registers
  logic [FRAME_W_W-1:0] frame_width_q;
  logic [FRAME_H_W-1:0] frame_height_q;
  logic                 cfg_hit;

  // effective frame geometry
  logic [EW-1:0]    fw_ext, eff_w, w_last;
  logic [ROW_W-1:0] h_last;

  // position of the next pixel
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [EW-1:0]    col_ext;
  logic             last_col, last_row;
  logic             in_accept;

  // input stage
  logic             a_v_q;
  rgb_t             a_pix_q;
  logic [AW-1:0]    a_col_q;
  logic [ROW_W-1:0] a_row_q;
  logic             a_int_q, a_brd_q, a_fend_q;
  logic             a_adv;

  line_pair_t lines_rd, lines_wr;
  rgb_t       pix_in, win_sum;
  res_load_t  load;
  logic       load_ready;

  // config port is always open; writes to width or height restart the frame
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_reg_e'(cfg_index_i))
      REG_FRAME_WIDTH:  cfg_hit = cfg_valid_i;
      REG_FRAME_HEIGHT: cfg_hit = cfg_valid_i;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RST;
      frame_height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_reg_e'(cfg_index_i) == REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[FRAME_W_W-1:0];
      end
      if (cfg_reg_e'(cfg_index_i) == REG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[FRAME_H_W-1:0];
      end
    end
  end

  // zero width or height counts as one; width saturates at the line store depth
  always_comb begin
    fw_ext = EW'(frame_width_q);
    if (fw_ext == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = fw_ext;
    end
    w_last = eff_w - EW'(1);
    h_last = (frame_height_q == '0) ? '0 : frame_height_q - ROW_W'(1);
  end

  assign col_ext   = EW'(col_q);
  assign last_col  = (col_ext == w_last);
  assign last_row  = (row_q == h_last);
  assign in_accept = in_valid_i && in_ready_o;

  // raster position, wraps to the top-left after the last pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input stage: holds the pixel while its line store word is read
  assign a_adv      = a_v_q && load_ready;
  assign in_ready_o = !a_v_q || a_adv;

  assign pix_in.red   = in_data_i.in_red;
  assign pix_in.green = in_data_i.in_green;
  assign pix_in.blue  = in_data_i.in_blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (in_ready_o) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_pix_q  <= pix_in;
      a_col_q  <= col_q;
      a_row_q  <= row_q;
      // interior pixel one up and one left is complete
      a_int_q  <= (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
      // pixel on the frame edge passes straight through
      a_brd_q  <= (row_q == '0) || (col_q == '0) || last_row || last_col;
      a_fend_q <= last_row && last_col;
    end
  end

  // line stores: upper takes the old lower row, lower takes the new pixel
  assign lines_wr.upper = lines_rd.lower;
  assign lines_wr.lower = a_pix_q;

  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (lines_rd),
    .wr_en_i   (a_adv),
    .wr_addr_i (a_col_q),
    .wr_data_i (lines_wr)
  );

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (a_adv),
    .lines_i (lines_rd),
    .pix_i   (a_pix_q),
    .sum_o   (win_sum)
  );

  // interior result first, border pass-through second
  always_comb begin
    load.int_v                 = a_int_q;
    load.brd_v                 = a_brd_q;
    load.int_res.out_row       = a_row_q - ROW_W'(1);
    load.int_res.out_col       = COL_W'(a_col_q - AW'(1));
    load.int_res.out_red       = win_sum.red;
    load.int_res.out_green     = win_sum.green;
    load.int_res.out_blue      = win_sum.blue;
    load.int_res.last_of_input = !a_brd_q;
    load.int_res.frame_end     = 1'b0;
    load.brd_res.out_row       = a_row_q;
    load.brd_res.out_col       = COL_W'(a_col_q);
    load.brd_res.out_red       = a_pix_q.red;
    load.brd_res.out_green     = a_pix_q.green;
    load.brd_res.out_blue      = a_pix_q.blue;
    load.brd_res.last_of_input = 1'b1;
    load.brd_res.frame_end     = a_fend_q;
  end

  bb3_result_q u_result_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (a_adv),
    .load_i       (load),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // end of frame only ever marks the final result of its pixel
  `BB3_ASSERT(a_fend_is_last, clk_i, rst_ni, out_valid_o && out_data_o.frame_end |-> out_data_o.last_of_input)

  // raster position stays inside the configured frame
  `BB3_NEVER(a_pos_in_frame, clk_i, rst_ni, (col_ext > w_last) || (row_q > h_last))

  // same-cycle read and write of one column only happens on one-pixel-wide frames
  `BB3_ASSERT(a_mem_no_clash, clk_i, rst_ni, in_accept && a_adv && (col_q == a_col_q) |-> (eff_w == EW'(1)))

endmodule

>>> sv/bb3_line_mem.sv
// two line stores kept as one memory word per column, registered read
`timescale 1ns / 1ps

module bb3_line_mem import bb3_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output line_pair_t    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  line_pair_t    wr_data_i
);

  line_pair_t mem_q [DEPTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/bb3_window.sv
// 3x3 window kept as per-column sums of floor(p / 9)
`timescale 1ns / 1ps

module bb3_window import bb3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  line_pair_t lines_i,
  input  rgb_t       pix_i,
  output rgb_t       sum_o
);

  colsum_t col0_q, col1_q;
  colsum_t new_col;

  assign new_col = col_sum(lines_i.upper, lines_i.lower, pix_i);

  // sum of the window after the new column has shifted in
  assign sum_o.red   = CH_W'(col0_q.red)   + CH_W'(col1_q.red)   + CH_W'(new_col.red);
  assign sum_o.green = CH_W'(col0_q.green) + CH_W'(col1_q.green) + CH_W'(new_col.green);
  assign sum_o.blue  = CH_W'(col0_q.blue)  + CH_W'(col1_q.blue)  + CH_W'(new_col.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col0_q <= '0;
      col1_q <= '0;
    end else if (shift_i) begin
      col0_q <= col1_q;
      col1_q <= new_col;
    end
  end

endmodule

>>> sv/bb3_result_q.sv
// two-slot result queue, head slot drives the output port
`timescale 1ns / 1ps

module bb3_result_q import bb3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_en_i,
  input  res_load_t load_i,
  output logic      load_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   out_data_o
);

  logic    v0_q, v1_q;
  result_t s0_q, s1_q;
  logic    pop;

  assign pop          = v0_q && out_ready_i;
  // load only into a queue that is empty after this cycle's pop
  assign load_ready_o = !v0_q || (!v1_q && out_ready_i);
  assign out_valid_o  = v0_q;
  assign out_data_o   = s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (load_en_i) begin
      v0_q <= load_i.int_v || load_i.brd_v;
      v1_q <= load_i.int_v && load_i.brd_v;
    end else if (pop) begin
      v0_q <= v1_q;
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      s0_q <= load_i.int_v ? load_i.int_res : load_i.brd_res;
      s1_q <= load_i.brd_res;
    end else if (pop) begin
      s0_q <= s1_q;
    end
  end

endmodule
